/* rtl/cgm_pkg.sv */
// shared types, constants and distance function of the color gradient magnitude core
package cgm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int WIDTH_W     = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd1024;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [7:0]       magnitude;
    logic             last_in_run;
    logic             frame_end;
  } result_t;

  // one classified request with its neighborhood
  typedef struct packed {
    pixel_t           pix;
    pixel_t           up;
    pixel_t           up_next;
    pixel_t           up2;
    pixel_t           up2_prev;
    pixel_t           prev;
    pixel_t           prev2;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_up;
    logic             top_row;
    logic             first_col;
    logic             second_col;
    logic             last_col;
    logic             last_row;
  } work_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] pix_dist(input pixel_t p, input pixel_t q);
    logic [7:0] db;
    logic [7:0] dg;
    logic [7:0] dr;
    logic [7:0] m;
    db = abs_diff(p.blue_in, q.blue_in);
    dg = abs_diff(p.green_in, q.green_in);
    dr = abs_diff(p.red_in, q.red_in);
    m = (db > dg) ? db : dg;
    pix_dist = (m > dr) ? m : dr;
  endfunction

endpackage

/* rtl/cgm_stream_if.sv */
// valid/ready stream interfaces for pixels and results
interface cgm_pixel_if;
  logic            valid;
  logic            ready;
  cgm_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgm_result_if;
  logic             valid;
  logic             ready;
  cgm_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/cgm_front.sv */
// front end: config, position counters, line buffers and request classification
module cgm_front (
  input  logic                           clk,
  input  logic                           rst,
  cgm_pixel_if.sink                      pixels,
  input  logic                           cfg_write,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [cgm_pkg::LEVEL_W-1:0]    q_level,
  output logic                           push,
  output cgm_pkg::work_t                 entry
);

  logic [cgm_pkg::WIDTH_W-1:0] width_reg;
  logic [cgm_pkg::ROW_W-1:0]   height_reg;
  logic [cgm_pkg::COL_W-1:0]   col_count;
  logic [cgm_pkg::ROW_W-1:0]   row_count;
  cgm_pkg::pixel_t             prev_pixel;
  cgm_pkg::pixel_t             prev_prev_pixel;

  cgm_pkg::pixel_t row_above     [cgm_pkg::MAX_WIDTH];
  cgm_pkg::pixel_t row_two_above [cgm_pkg::MAX_WIDTH];

  logic [cgm_pkg::WIDTH_W-1:0] w_last_full;
  logic [cgm_pkg::COL_W-1:0]   w_last;
  logic [cgm_pkg::ROW_W-1:0]   h_last;
  logic [cgm_pkg::COL_W-1:0]   c;
  logic [cgm_pkg::ROW_W-1:0]   r;
  logic [cgm_pkg::ADDR_W-1:0]  addr;
  logic                        accept;
  logic [cgm_pkg::LEVEL_W:0]   fill;

  cgm_pkg::pixel_t             rd_up;
  cgm_pkg::pixel_t             rd_up_next;
  cgm_pkg::pixel_t             rd_up2;
  cgm_pkg::pixel_t             rd_up2_prev;

  logic                        s1_valid;
  cgm_pkg::pixel_t             s1_pix;
  cgm_pkg::pixel_t             s1_prev;
  cgm_pkg::pixel_t             s1_prev2;
  logic [cgm_pkg::ROW_W-1:0]   s1_row;
  logic [cgm_pkg::COL_W-1:0]   s1_col;
  logic                        s1_has_up;
  logic                        s1_top_row;
  logic                        s1_first_col;
  logic                        s1_second_col;
  logic                        s1_last_col;
  logic                        s1_last_row;

  logic                        fwd_valid;
  logic [cgm_pkg::ADDR_W-1:0]  fwd_addr;
  cgm_pkg::pixel_t             fwd_data;
  logic [cgm_pkg::ADDR_W-1:0]  s1_addr_prev;

  always_comb begin
    if (width_reg < 11'd2) begin
      w_last_full = 11'd1;
    end else if (width_reg > 11'(cgm_pkg::MAX_WIDTH)) begin
      w_last_full = 11'(cgm_pkg::MAX_WIDTH - 1);
    end else begin
      w_last_full = width_reg - 11'd1;
    end
  end

  assign w_last = w_last_full[cgm_pkg::COL_W-1:0];
  assign h_last = (height_reg < 12'd2) ? 12'd1 : (height_reg - 12'd1);
  assign c      = (col_count > w_last) ? w_last : col_count;
  assign r      = (row_count > h_last) ? h_last : row_count;
  assign addr   = c[cgm_pkg::ADDR_W-1:0];

  assign fill = {1'b0, q_level} + {{cgm_pkg::LEVEL_W{1'b0}}, s1_valid};
  assign pixels.ready = fill < (cgm_pkg::LEVEL_W + 1)'(cgm_pkg::QUEUE_DEPTH);
  assign accept = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg       <= cgm_pkg::WIDTH_RESET;
      height_reg      <= cgm_pkg::HEIGHT_RESET;
      col_count       <= '0;
      row_count       <= '0;
      prev_pixel      <= '0;
      prev_prev_pixel <= '0;
      s1_valid        <= 1'b0;
      fwd_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == cgm_pkg::CFG_IMAGE_WIDTH) begin
          width_reg <= cfg_data[cgm_pkg::WIDTH_W-1:0];
        end else if (cfg_index == cgm_pkg::CFG_IMAGE_HEIGHT) begin
          height_reg <= cfg_data[cgm_pkg::ROW_W-1:0];
        end
      end
      if (accept) begin
        prev_prev_pixel <= prev_pixel;
        prev_pixel      <= pixels.data;
        if (c == w_last) begin
          col_count <= '0;
          row_count <= (r == h_last) ? '0 : (r + 12'd1);
        end else begin
          col_count <= c + 10'd1;
          row_count <= r;
        end
      end
      s1_valid <= accept;
      if (s1_valid) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  // line buffers: reads return the value before this cycle's write
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up       <= row_above[addr];
      rd_up_next  <= row_above[addr + 10'd1];
      rd_up2      <= row_two_above[addr];
      rd_up2_prev <= row_two_above[addr - 10'd1];
      row_above[addr] <= pixels.data;
    end
    if (s1_valid) begin
      row_two_above[s1_col[cgm_pkg::ADDR_W-1:0]] <= rd_up;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix        <= pixels.data;
      s1_prev       <= prev_pixel;
      s1_prev2      <= prev_prev_pixel;
      s1_row        <= r;
      s1_col        <= c;
      s1_has_up     <= (r != '0);
      s1_top_row    <= (r == 12'd1);
      s1_first_col  <= (c == '0);
      s1_second_col <= (c == 10'd1);
      s1_last_col   <= (c == w_last);
      s1_last_row   <= (r == h_last);
    end
    if (s1_valid) begin
      fwd_addr <= s1_col[cgm_pkg::ADDR_W-1:0];
      fwd_data <= rd_up;
    end
  end

  // bypass the second buffer write that lands on the same edge as the read
  assign s1_addr_prev = s1_col[cgm_pkg::ADDR_W-1:0] - 10'd1;

  always_comb begin
    entry            = '0;
    entry.pix        = s1_pix;
    entry.up         = rd_up;
    entry.up_next    = rd_up_next;
    entry.up2        = (fwd_valid && fwd_addr == s1_col[cgm_pkg::ADDR_W-1:0]) ?
                       fwd_data : rd_up2;
    entry.up2_prev   = (fwd_valid && fwd_addr == s1_addr_prev) ? fwd_data : rd_up2_prev;
    entry.prev       = s1_prev;
    entry.prev2      = s1_prev2;
    entry.row        = s1_row;
    entry.col        = s1_col;
    entry.has_up     = s1_has_up;
    entry.top_row    = s1_top_row;
    entry.first_col  = s1_first_col;
    entry.second_col = s1_second_col;
    entry.last_col   = s1_last_col;
    entry.last_row   = s1_last_row;
  end

  assign push = s1_valid;

endmodule

/* rtl/cgm_queue.sv */
// short request queue between front and back end
module cgm_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  cgm_pkg::work_t              push_data,
  input  logic                        pop,
  output logic                        not_empty,
  output cgm_pkg::work_t              head,
  output logic [cgm_pkg::LEVEL_W-1:0] level
);

  cgm_pkg::work_t             slots [cgm_pkg::QUEUE_DEPTH];
  logic [cgm_pkg::QPTR_W-1:0] wr_ptr;
  logic [cgm_pkg::QPTR_W-1:0] rd_ptr;

  assign not_empty = (level != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        level <= level + 3'd1;
      end else if (pop && !push) begin
        level <= level - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/cgm_back.sv */
// back end: expands each request into its results and computes the magnitudes
module cgm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  cgm_pkg::work_t head,
  output logic           pop,
  cgm_result_if.source   results
);

  logic [2:0]                done;
  logic [2:0]                rem;
  logic [2:0]                sel;
  logic                      final_one;
  logic                      can_load;
  logic                      load;
  logic [7:0]                hd;
  logic [7:0]                vd;
  logic                      h2;
  logic                      v2;
  logic [8:0]                hs;
  logic [8:0]                vs;
  logic [9:0]                total;
  logic [cgm_pkg::ROW_W-1:0] row;
  logic [cgm_pkg::COL_W-1:0] col;
  logic                      fe;

  // bit 0 upper-row result, bit 1 last-row lagging result, bit 2 frame corner
  assign rem = {head.last_row && head.last_col,
                head.last_row && !head.first_col,
                head.has_up} & ~done;
  assign sel       = rem & (~rem + 3'd1);
  assign final_one = ((rem & ~sel) == 3'd0);
  assign can_load  = !results.valid || results.ready;
  assign load      = head_valid && can_load && (rem != 3'd0);
  assign pop       = head_valid && ((rem == 3'd0) || (can_load && final_one));

  always_comb begin
    hd  = '0;
    vd  = '0;
    h2  = 1'b0;
    v2  = 1'b0;
    row = head.row;
    col = head.col;
    fe  = 1'b0;
    priority if (rem[0]) begin
      row = head.row - 12'd1;
      if (head.first_col) begin
        hd = cgm_pkg::pix_dist(head.up_next, head.up);
        h2 = 1'b1;
      end else if (head.last_col) begin
        hd = cgm_pkg::pix_dist(head.up, head.up2_prev);
        h2 = 1'b1;
      end else begin
        hd = cgm_pkg::pix_dist(head.up2_prev, head.up_next);
      end
      vd = head.top_row ? cgm_pkg::pix_dist(head.pix, head.up)
                        : cgm_pkg::pix_dist(head.pix, head.up2);
      v2 = head.top_row;
    end else if (rem[1]) begin
      col = head.col - 10'd1;
      hd  = head.second_col ? cgm_pkg::pix_dist(head.pix, head.prev)
                            : cgm_pkg::pix_dist(head.prev2, head.pix);
      h2  = head.second_col;
      vd  = cgm_pkg::pix_dist(head.prev, head.up2_prev);
      v2  = 1'b1;
    end else begin
      hd = cgm_pkg::pix_dist(head.pix, head.prev);
      h2 = 1'b1;
      vd = cgm_pkg::pix_dist(head.pix, head.up);
      v2 = 1'b1;
      fe = 1'b1;
    end
  end

  assign hs    = h2 ? {hd, 1'b0} : {1'b0, hd};
  assign vs    = v2 ? {vd, 1'b0} : {1'b0, vd};
  assign total = {1'b0, hs} + {1'b0, vs};

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= '0;
      results.valid <= 1'b0;
    end else begin
      if (pop) begin
        done <= '0;
      end else if (load) begin
        done <= done | sel;
      end
      if (load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.data.out_row     <= row;
      results.data.out_col     <= col;
      results.data.magnitude   <= (total > 10'd255) ? 8'hFF : total[7:0];
      results.data.last_in_run <= final_one;
      results.data.frame_end   <= fe;
    end
  end

endmodule

/* rtl/color_gradient_magnitude_core.sv */
// top level of the color gradient magnitude core
// Takes BGR pixels in raster order and gives, per pixel, the max-channel
// gradient magnitude saturated at 255. A pixel's result is released by the
// pixel below it, so results trail the input by one row; the last row is
// released one column late and the frame's final pixel releases the rest.
// Pixels are taken one per clock while the queue has room and results leave
// one per clock while the receiver is ready, via a single output register;
// on the last row most pixels yield two results, the frame's final pixel
// three, so the input slows there. Results pass through the registered
// line-buffer read, the queue and the result register. No clearing pass is
// needed after reset; widths and heights take effect on the next pixel, so
// they must be written between frames with nothing in flight (unchecked).
module color_gradient_magnitude_core (
  input  logic                           clk,
  input  logic                           rst,
  cgm_pixel_if.sink                      pixels,
  cgm_result_if.source                   results,
  input  logic                           cfg_write,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                        q_push;
  logic                        q_pop;
  logic                        q_not_empty;
  logic [cgm_pkg::LEVEL_W-1:0] q_level;
  cgm_pkg::work_t              q_in;
  cgm_pkg::work_t              q_head;

  cgm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .push      (q_push),
    .entry     (q_in)
  );

  cgm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .level     (q_level)
  );

  cgm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (q_head),
    .pop        (q_pop),
    .results    (results)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && !q_pop && q_level == cgm_pkg::LEVEL_W'(cgm_pkg::QUEUE_DEPTH)))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("pop from empty request queue");

  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.frame_end) |-> results.data.last_in_run)
    else $error("frame end result is not last of its run");

endmodule
